// ----- sv/decimal_fixed_point_alu_assert.svh -----
// assertion macros shared by the decimal fixed-point alu
`ifndef DECIMAL_FIXED_POINT_ALU_ASSERT_SVH
`define DECIMAL_FIXED_POINT_ALU_ASSERT_SVH

// clocked check, switched off while reset is low
`define DFPA_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// clocked check that also holds during reset
`define DFPA_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ----- sv/dfpa_pkg.sv -----
// shared types, codes and the power-of-ten table of the decimal fixed-point alu
`timescale 1ns / 1ps

package dfpa_pkg;

    localparam int OP_W    = 3;
    localparam int PREC_W  = 5;
    localparam int ST_W    = 2;
    localparam int SCALE_W = 64;

    localparam logic [OP_W-1:0] OP_ADD  = 3'd0;
    localparam logic [OP_W-1:0] OP_SUB  = 3'd1;
    localparam logic [OP_W-1:0] OP_MUL  = 3'd2;
    localparam logic [OP_W-1:0] OP_DIV  = 3'd3;
    localparam logic [OP_W-1:0] OP_CONV = 3'd4;

    localparam logic [ST_W-1:0] ST_OK           = 2'd0;
    localparam logic [ST_W-1:0] ST_TOO_LARGE    = 2'd1;
    localparam logic [ST_W-1:0] ST_OUT_OF_RANGE = 2'd2;

    typedef struct packed {
        logic            valid;
        logic [ST_W-1:0] status;
    } ctl_t;

    // 10^p for p up to 19
    function automatic logic [SCALE_W-1:0] pow10(input logic [PREC_W-1:0] p);
        logic [SCALE_W-1:0] r;
        case (p)
            5'd0:    r = 64'd1;
            5'd1:    r = 64'd10;
            5'd2:    r = 64'd100;
            5'd3:    r = 64'd1000;
            5'd4:    r = 64'd10000;
            5'd5:    r = 64'd100000;
            5'd6:    r = 64'd1000000;
            5'd7:    r = 64'd10000000;
            5'd8:    r = 64'd100000000;
            5'd9:    r = 64'd1000000000;
            5'd10:   r = 64'd10000000000;
            5'd11:   r = 64'd100000000000;
            5'd12:   r = 64'd1000000000000;
            5'd13:   r = 64'd10000000000000;
            5'd14:   r = 64'd100000000000000;
            5'd15:   r = 64'd1000000000000000;
            5'd16:   r = 64'd10000000000000000;
            5'd17:   r = 64'd100000000000000000;
            5'd18:   r = 64'd1000000000000000000;
            default: r = 64'd10000000000000000000;
        endcase
        return r;
    endfunction

endpackage

// ----- sv/dfpa_mul_cell.sv -----
// one shift-and-add cell of the multiplier row
`timescale 1ns / 1ps

module dfpa_mul_cell #(
    parameter int W = 64
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         en,
    input  dfpa_pkg::ctl_t               ctl_in,
    input  logic [W-1:0]                 x_in,
    input  logic [W+dfpa_pkg::SCALE_W-1:0] y_in,
    input  logic [W+dfpa_pkg::SCALE_W-1:0] acc_in,
    input  logic [dfpa_pkg::SCALE_W-1:0] d_in,
    output dfpa_pkg::ctl_t               ctl_out,
    output logic [W-1:0]                 x_out,
    output logic [W+dfpa_pkg::SCALE_W-1:0] y_out,
    output logic [W+dfpa_pkg::SCALE_W-1:0] acc_out,
    output logic [dfpa_pkg::SCALE_W-1:0] d_out
);
    import dfpa_pkg::*;

    localparam int NW = W + SCALE_W;

    ctl_t            ctl_reg;
    logic [W-1:0]    x_reg;
    logic [NW-1:0]   y_reg;
    logic [NW-1:0]   acc_reg;
    logic [NW-1:0]   acc_next;
    logic [SCALE_W-1:0] d_reg;

    // add the shifted multiplicand when the current multiplier bit is set
    assign acc_next = acc_in + (x_in[0] ? y_in : '0);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ctl_reg <= '0;
        end
        else if (en)
        begin
            ctl_reg <= ctl_in;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            x_reg   <= x_in >> 1;
            y_reg   <= y_in << 1;
            acc_reg <= acc_next;
            d_reg   <= d_in;
        end
    end

    assign ctl_out = ctl_reg;
    assign x_out   = x_reg;
    assign y_out   = y_reg;
    assign acc_out = acc_reg;
    assign d_out   = d_reg;

endmodule

// ----- sv/dfpa_div_cell.sv -----
// one restoring step cell of the divider row
`timescale 1ns / 1ps

module dfpa_div_cell #(
    parameter int W = 64
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         en,
    input  dfpa_pkg::ctl_t               ctl_in,
    input  logic [dfpa_pkg::SCALE_W-1:0] r_in,
    input  logic [W-1:0]                 nq_in,
    input  logic [dfpa_pkg::SCALE_W-1:0] d_in,
    output dfpa_pkg::ctl_t               ctl_out,
    output logic [dfpa_pkg::SCALE_W-1:0] r_out,
    output logic [W-1:0]                 nq_out,
    output logic [dfpa_pkg::SCALE_W-1:0] d_out
);
    import dfpa_pkg::*;

    ctl_t               ctl_reg;
    logic [SCALE_W-1:0] r_reg;
    logic [SCALE_W-1:0] r_next;
    logic [W-1:0]       nq_reg;
    logic [W-1:0]       nq_next;
    logic [SCALE_W-1:0] d_reg;
    logic [SCALE_W:0]   trial;
    logic [SCALE_W:0]   diff;
    logic               ge;

    // bring down the next numerator bit, subtract if it fits
    assign trial   = {r_in, nq_in[W-1]};
    assign ge      = trial >= {1'b0, d_in};
    assign diff    = trial - {1'b0, d_in};
    assign r_next  = ge ? diff[SCALE_W-1:0] : trial[SCALE_W-1:0];
    assign nq_next = {nq_in[W-2:0], ge};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ctl_reg <= '0;
        end
        else if (en)
        begin
            ctl_reg <= ctl_in;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            r_reg  <= r_next;
            nq_reg <= nq_next;
            d_reg  <= d_in;
        end
    end

    assign ctl_out = ctl_reg;
    assign r_out   = r_reg;
    assign nq_out  = nq_reg;
    assign d_out   = d_reg;

endmodule

// ----- sv/decimal_fixed_point_alu.sv -----
// top level of the decimal fixed-point alu: input stage, multiplier row, divider row
`timescale 1ns / 1ps
// usage
// - s_axis carries one item: op, operand_a, operand_b, target_precision
// - m_axis returns exactly one item per input: result_value and status
// - cfg_valid/cfg_data writes working_precision; cfg_ready is always high,
//   write it only while no item is in flight
// - every op becomes x * y / d: a row of VALUE_WIDTH shift-and-add cells
//   builds the product, a compare flags a quotient too wide, then a row of
//   VALUE_WIDTH restoring cells produces one quotient bit each
// - an accepted item is registered first in the input stage, then in each
//   multiplier cell in turn and then in each divider cell in turn
// - throughput is one item per cycle while the output is not stalled; every
//   cell passes its item on each cycle that the row advances
// - the row advances whenever the output is empty or taken; when the
//   receiver stalls a held result, the whole row holds, and the input
//   stage still takes one more item if it is empty
// - reset clears all valid flags and sets working_precision to zero
// - an item with an error status always returns a zero value

module decimal_fixed_point_alu #(
    parameter int VALUE_WIDTH   = 64,
    parameter int MAX_PRECISION = 19
) (
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  logic                                   cfg_valid,
    output logic                                   cfg_ready,
    input  logic [dfpa_pkg::PREC_W-1:0]            cfg_data,
    input  logic                                   s_axis_tvalid,
    output logic                                   s_axis_tready,
    // op, operand_a, operand_b, target_precision, zero fill
    input  logic [((2*VALUE_WIDTH+8+7)/8)*8-1:0]   s_axis_tdata,
    output logic                                   m_axis_tvalid,
    input  logic                                   m_axis_tready,
    // result_value, status, zero fill
    output logic [((VALUE_WIDTH+2+7)/8)*8-1:0]     m_axis_tdata
);
    import dfpa_pkg::*;

    localparam int W     = VALUE_WIDTH;
    localparam int NW    = W + SCALE_W;
    localparam int OUT_W = ((W+2+7)/8)*8;
    localparam logic [PREC_W-1:0] MAXP = PREC_W'(MAX_PRECISION);

    // configuration register
    logic [PREC_W-1:0] wp_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg <= '0;
        end
        else if (cfg_valid)
        begin
            wp_reg <= cfg_data;
        end
    end

    // row advance: output empty or being taken
    logic en;
    logic out_valid;

    assign en = !out_valid || m_axis_tready;

    // input stage
    logic              in_valid_reg;
    logic [OP_W-1:0]   op_reg;
    logic [W-1:0]      a_reg;
    logic [W-1:0]      b_reg;
    logic [PREC_W-1:0] tp_reg;
    logic              in_load;

    assign s_axis_tready = en || !in_valid_reg;
    assign in_load       = s_axis_tvalid && s_axis_tready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (s_axis_tready)
        begin
            in_valid_reg <= s_axis_tvalid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_load)
        begin
            op_reg <= s_axis_tdata[OP_W-1:0];
            a_reg  <= s_axis_tdata[OP_W +: W];
            b_reg  <= s_axis_tdata[OP_W+W +: W];
            tp_reg <= s_axis_tdata[OP_W+2*W +: PREC_W];
        end
    end

    // decode each op into multiplier x, multiplicand y and divisor d
    logic [PREC_W-1:0]  wpc;
    logic [PREC_W-1:0]  tpc;
    logic [SCALE_W-1:0] scale;
    logic [W:0]         sum;
    logic [W-1:0]       dec_x;
    logic [SCALE_W-1:0] dec_y;
    logic [SCALE_W-1:0] dec_d;
    ctl_t               dec_ctl;

    assign wpc   = (wp_reg > MAXP) ? MAXP : wp_reg;
    assign tpc   = (tp_reg > MAXP) ? MAXP : tp_reg;
    assign scale = pow10(wpc);
    assign sum   = {1'b0, a_reg} + {1'b0, b_reg};

    always_comb
    begin
        dec_x          = a_reg;
        dec_y          = SCALE_W'(1);
        dec_d          = SCALE_W'(1);
        dec_ctl.valid  = in_valid_reg;
        dec_ctl.status = ST_OK;
        case (op_reg)
            OP_ADD:
            begin
                dec_x = sum[W-1:0];
                if (sum[W])
                begin
                    dec_ctl.status = ST_TOO_LARGE;
                end
            end
            OP_SUB:
            begin
                dec_x = a_reg - b_reg;
                if (b_reg > a_reg)
                begin
                    dec_ctl.status = ST_OUT_OF_RANGE;
                end
            end
            OP_MUL:
            begin
                dec_y = SCALE_W'(b_reg);
                dec_d = scale;
            end
            OP_DIV:
            begin
                dec_y = scale;
                dec_d = SCALE_W'(b_reg);
                if (b_reg == '0)
                begin
                    dec_ctl.status = ST_OUT_OF_RANGE;
                end
            end
            OP_CONV:
            begin
                // scale up by multiplying, down by dividing
                if (tpc > wpc)
                begin
                    dec_y = pow10(tpc - wpc);
                end
                else
                begin
                    dec_d = pow10(wpc - tpc);
                end
            end
            default:
            begin
                dec_ctl.status = ST_OUT_OF_RANGE;
            end
        endcase
    end

    // multiplier row
    ctl_t               m_ctl [W+1];
    logic [W-1:0]       m_x   [W+1];
    logic [NW-1:0]      m_y   [W+1];
    logic [NW-1:0]      m_acc [W+1];
    logic [SCALE_W-1:0] m_d   [W+1];

    assign m_ctl[0] = dec_ctl;
    assign m_x[0]   = dec_x;
    assign m_y[0]   = NW'(dec_y);
    assign m_acc[0] = '0;
    assign m_d[0]   = dec_d;

    for (genvar i = 0; i < W; i++)
    begin : g_mul
        dfpa_mul_cell #(.W(W)) u_cell (
            .clk     (clk),
            .rst_n   (rst_n),
            .en      (en),
            .ctl_in  (m_ctl[i]),
            .x_in    (m_x[i]),
            .y_in    (m_y[i]),
            .acc_in  (m_acc[i]),
            .d_in    (m_d[i]),
            .ctl_out (m_ctl[i+1]),
            .x_out   (m_x[i+1]),
            .y_out   (m_y[i+1]),
            .acc_out (m_acc[i+1]),
            .d_out   (m_d[i+1])
        );
    end

    // quotient fits in W bits only when the product's high part is below d
    logic [SCALE_W-1:0] prod_hi;
    ctl_t               ovf_ctl;

    assign prod_hi = m_acc[W][NW-1:W];

    always_comb
    begin
        ovf_ctl = m_ctl[W];
        if (m_ctl[W].status == ST_OK && prod_hi >= m_d[W])
        begin
            ovf_ctl.status = ST_TOO_LARGE;
        end
    end

    // divider row
    ctl_t               q_ctl [W+1];
    logic [SCALE_W-1:0] q_r   [W+1];
    logic [W-1:0]       q_nq  [W+1];
    logic [SCALE_W-1:0] q_d   [W+1];

    assign q_ctl[0] = ovf_ctl;
    assign q_r[0]   = prod_hi;
    assign q_nq[0]  = m_acc[W][W-1:0];
    assign q_d[0]   = m_d[W];

    for (genvar j = 0; j < W; j++)
    begin : g_div
        dfpa_div_cell #(.W(W)) u_cell (
            .clk     (clk),
            .rst_n   (rst_n),
            .en      (en),
            .ctl_in  (q_ctl[j]),
            .r_in    (q_r[j]),
            .nq_in   (q_nq[j]),
            .d_in    (q_d[j]),
            .ctl_out (q_ctl[j+1]),
            .r_out   (q_r[j+1]),
            .nq_out  (q_nq[j+1]),
            .d_out   (q_d[j+1])
        );
    end

    // output: last divider cell is the result register
    logic [W-1:0]    res_value;
    logic [ST_W-1:0] res_status;

    assign out_valid     = q_ctl[W].valid;
    assign res_status    = q_ctl[W].status;
    assign res_value     = (res_status == ST_OK) ? q_nq[W] : '0;
    assign m_axis_tvalid = out_valid;
    assign m_axis_tdata  = OUT_W'({res_status, res_value});

    `include "decimal_fixed_point_alu_assert.svh"

    `DFPA_ASSERT(a_err_zero, (m_axis_tvalid && res_status != ST_OK) |-> (res_value == '0), "error item with nonzero value")
    `DFPA_ASSERT(a_status_code, m_axis_tvalid |-> (res_status != 2'd3), "undefined status code")
    `DFPA_ASSERT(a_stall_cause, !s_axis_tready |-> (m_axis_tvalid && !m_axis_tready && in_valid_reg), "input stalled without output stall")
    `DFPA_ASSERT_ALWAYS(a_cfg_ready, cfg_ready, "config port not ready")

endmodule
